FILE: sv/sagh_pkg.sv
package sagh_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int LINK_W = $clog2(SLOT_COUNT + 1);

    localparam logic [15:0] GEN_LAST = 16'd65534;

    localparam logic [7:0] KIND_POINT = 8'd0;
    localparam logic [7:0] KIND_DIR = 8'd1;

    typedef enum logic [2:0] {
        REQ_CREATE     = 3'd0,
        REQ_REMOVE     = 3'd1,
        REQ_SET_POS    = 3'd2,
        REQ_SET_BRIGHT = 3'd3,
        REQ_READ       = 3'd4
    } req_code_e;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_STALE  = 3'd2,
        ST_DIRPOS = 3'd3,
        ST_KIND   = 3'd4
    } status_e;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  handle_kind;
        logic [15:0] handle_generation;
        logic [5:0]  handle_slot;
        logic [31:0] pos_x_in;
        logic [31:0] pos_y_in;
        logic [31:0] pos_z_in;
        logic [31:0] brightness_in;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_kind;
        logic [15:0] out_generation;
        logic [5:0]  out_slot;
        logic [31:0] pos_x_out;
        logic [31:0] pos_y_out;
        logic [31:0] pos_z_out;
        logic [31:0] brightness_out;
        logic [6:0]  live_lights;
    } rsp_t;

    typedef struct packed {
        logic [15:0] gen;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] bright;
    } slot_rec_t;

    typedef struct packed {
        logic              pop;
        logic              push;
        logic [SLOT_W-1:0] slot;
    } fl_cmd_t;

endpackage

FILE: sv/sagh_if.sv
interface sagh_req_if;
    logic              valid;
    logic              ready;
    sagh_pkg::req_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sagh_rsp_if;
    logic              valid;
    logic              ready;
    sagh_pkg::rsp_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: sv/sagh_slot_mem.sv
module sagh_slot_mem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [sagh_pkg::SLOT_W-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [sagh_pkg::SLOT_W-1:0] wr_addr,
    input  sagh_pkg::slot_rec_t         wr_data,
    output sagh_pkg::slot_rec_t         rd_data
);
    import sagh_pkg::*;

    slot_rec_t               mem [SLOT_COUNT];
    slot_rec_t               rd_raw_reg;
    logic                    rd_ok_reg;
    logic [SLOT_COUNT-1:0]   written_reg;
    logic                    hit;

    assign hit = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (hit)
            begin
                rd_raw_reg <= wr_data;
            end
            else
            begin
                rd_raw_reg <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= hit || written_reg[rd_addr];
            end
        end
    end

    // An entry never written since reset reads as all zero.
    assign rd_data = rd_ok_reg ? rd_raw_reg : '0;

endmodule

FILE: sv/sagh_free_list.sv
module sagh_free_list (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sagh_pkg::fl_cmd_t           cmd,
    output logic [sagh_pkg::LINK_W-1:0] head
);
    import sagh_pkg::*;

    logic [LINK_W-1:0]     link_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] link_wr_reg;
    logic [LINK_W-1:0]     free_head_reg;
    logic [LINK_W-1:0]     link_rd_reg;
    logic [SLOT_W-1:0]     link_idx_reg;
    logic                  link_ok_reg;
    logic [LINK_W-1:0]     head_link;
    logic [SLOT_W-1:0]     pop_idx;

    // The link of the current head is kept ready, so a pop needs no read in its own cycle.
    assign head_link = link_ok_reg ? link_rd_reg : LINK_W'(link_idx_reg) + LINK_W'(1);
    assign pop_idx = head_link[SLOT_W-1:0];
    assign head = free_head_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            link_mem[cmd.slot] <= free_head_reg;
        end
        if (cmd.pop)
        begin
            link_rd_reg <= link_mem[pop_idx];
        end
        else if (cmd.push)
        begin
            link_rd_reg <= free_head_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_wr_reg   <= '0;
            free_head_reg <= '0;
            link_idx_reg  <= '0;
            link_ok_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.pop)
            begin
                free_head_reg <= head_link;
                link_idx_reg  <= pop_idx;
                link_ok_reg   <= link_wr_reg[pop_idx];
            end
            else if (cmd.push)
            begin
                free_head_reg            <= LINK_W'(cmd.slot);
                link_ok_reg              <= 1'b1;
                link_wr_reg[cmd.slot]    <= 1'b1;
            end
        end
    end

endmodule

FILE: sv/slot_allocator_with_generation_handles_top.sv
// A request item passes through the request register and then the result register.
// Throughput: one request item per cycle while the result side is not stalled; the table has a single write port.
// An item is taken while an earlier result still waits, through the request register.
// Reset is asynchronous and active low; it empties the table and rebuilds the free list
// in ascending slot order at once, with no clearing pass.
module slot_allocator_with_generation_handles_top (
    input  logic       clk,
    input  logic       rst_n,
    sagh_req_if.sink   req,
    sagh_rsp_if.source rsp
);
    import sagh_pkg::*;

    req_t                  b_reg;
    logic                  b_valid_reg;
    logic                  b_fire;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    logic                  out_valid_reg;
    logic [15:0]           gen_reg;
    logic [15:0]           gen_next;
    logic [LINK_W-1:0]     live_reg;
    logic [LINK_W-1:0]     live_next;
    logic [SLOT_COUNT-1:0] slot_valid_reg;
    logic [SLOT_COUNT-1:0] slot_valid_next;

    slot_rec_t             rd_data;
    slot_rec_t             wr_data;
    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    fl_cmd_t               fl_cmd;
    logic [LINK_W-1:0]     fl_head;

    logic [SLOT_W-1:0]     slot_idx;
    logic [SLOT_W-1:0]     head_idx;
    logic                  in_range;
    logic                  has_free;

    assign b_fire = b_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !b_valid_reg || b_fire;
    assign rsp.valid = out_valid_reg;
    assign rsp.data = rsp_reg;

    sagh_slot_mem u_slot_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (req.valid && req.ready),
        .rd_addr (SLOT_W'(req.data.handle_slot)),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    sagh_free_list u_free_list (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fl_cmd),
        .head  (fl_head)
    );

    assign slot_idx = SLOT_W'(b_reg.handle_slot);
    assign head_idx = fl_head[SLOT_W-1:0];
    assign in_range = 32'(b_reg.handle_slot) < SLOT_COUNT;
    assign has_free = 32'(fl_head) < SLOT_COUNT;

    always_comb
    begin
        rsp_next        = '0;
        rsp_next.status = ST_OK;
        wr_en           = 1'b0;
        wr_addr         = slot_idx;
        wr_data         = rd_data;
        fl_cmd          = '0;
        fl_cmd.slot     = slot_idx;
        slot_valid_next = slot_valid_reg;
        live_next       = live_reg;
        gen_next        = gen_reg;

        if (b_fire)
        begin
            unique case (b_reg.req_type)
                REQ_CREATE:
                begin
                    gen_next = (gen_reg == GEN_LAST) ? '0 : gen_reg + 16'd1;
                    if (!has_free)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        wr_en                     = 1'b1;
                        wr_addr                   = head_idx;
                        wr_data.gen               = gen_reg;
                        wr_data.pos_x             = b_reg.pos_x_in;
                        wr_data.pos_y             = b_reg.pos_y_in;
                        wr_data.pos_z             = b_reg.pos_z_in;
                        wr_data.bright            = b_reg.brightness_in;
                        fl_cmd.pop                = 1'b1;
                        slot_valid_next[head_idx] = 1'b1;
                        live_next                 = live_reg + LINK_W'(1);
                        rsp_next.out_generation   = gen_reg;
                        rsp_next.out_slot         = 6'(fl_head);
                    end
                end
                REQ_REMOVE:
                begin
                    rsp_next.out_slot = b_reg.handle_slot;
                    if (b_reg.handle_kind != KIND_POINT || !in_range
                        || !slot_valid_reg[slot_idx]
                        || rd_data.gen != b_reg.handle_generation)
                    begin
                        rsp_next.status = ST_STALE;
                    end
                    else
                    begin
                        wr_en                     = 1'b1;
                        wr_data.pos_x             = '0;
                        wr_data.pos_y             = '0;
                        wr_data.pos_z             = '0;
                        wr_data.bright            = '0;
                        fl_cmd.push               = 1'b1;
                        slot_valid_next[slot_idx] = 1'b0;
                        live_next                 = live_reg - LINK_W'(1);
                    end
                end
                REQ_SET_POS:
                begin
                    rsp_next.out_slot = b_reg.handle_slot;
                    if (b_reg.handle_kind == KIND_DIR)
                    begin
                        rsp_next.status = ST_DIRPOS;
                    end
                    else if (b_reg.handle_kind != KIND_POINT)
                    begin
                        rsp_next.status = ST_KIND;
                    end
                    else if (!in_range)
                    begin
                        rsp_next.status = ST_STALE;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_data.pos_x = b_reg.pos_x_in;
                        wr_data.pos_y = b_reg.pos_y_in;
                        wr_data.pos_z = b_reg.pos_z_in;
                    end
                end
                REQ_SET_BRIGHT:
                begin
                    rsp_next.out_slot = b_reg.handle_slot;
                    if (b_reg.handle_kind != KIND_POINT)
                    begin
                        rsp_next.status = ST_KIND;
                    end
                    else if (!in_range)
                    begin
                        rsp_next.status = ST_STALE;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_data.bright = b_reg.brightness_in;
                    end
                end
                REQ_READ:
                begin
                    rsp_next.out_slot = b_reg.handle_slot;
                    if (!in_range)
                    begin
                        rsp_next.status = ST_STALE;
                    end
                    else
                    begin
                        rsp_next.out_generation = rd_data.gen;
                        rsp_next.pos_x_out      = rd_data.pos_x;
                        rsp_next.pos_y_out      = rd_data.pos_y;
                        rsp_next.pos_z_out      = rd_data.pos_z;
                        rsp_next.brightness_out = rd_data.bright;
                    end
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
        end

        rsp_next.live_lights = 7'(live_next);
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            b_reg <= req.data;
        end
        if (b_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            gen_reg        <= '0;
            live_reg       <= '0;
            slot_valid_reg <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                b_valid_reg <= req.valid;
            end
            if (b_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            gen_reg        <= gen_next;
            live_reg       <= live_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    a_live_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == 32'(live_reg))
        else $error("Live count differs from the number of valid slots.");

    a_empty_list_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(fl_head) == SLOT_COUNT) == (32'(live_reg) == SLOT_COUNT))
        else $error("Free list state disagrees with the live count.");

    a_gen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != 16'hFFFF)
        else $error("Generation counter left its modulus.");

    a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        b_fire |=> out_valid_reg)
        else $error("A processed item produced no result.");

    a_no_write_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && b_reg.req_type == REQ_CREATE && !has_free) |-> !wr_en && !fl_cmd.pop)
        else $error("A create on a full table touched the table.");

endmodule
